@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent check macros used by c_subset_lexer
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression holds at every clock edge outside reset
`define CHECK_ALWAYS(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("check failed");

// same-cycle implication
`define CHECK_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("check failed");

// next-cycle implication
`define CHECK_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("check failed");

`endif

@@ rtl/clex_pkg.sv @@
// ----------------------------------------------------------------------------
// clex_pkg
// types, token codes and character class helpers of the c subset lexer
// ----------------------------------------------------------------------------
`default_nettype none

package clex_pkg;

   // scan modes
   typedef enum logic [3:0] {
      MODE_START  = 4'd0,
      MODE_SLASH  = 4'd1,
      MODE_LINE   = 4'd2,
      MODE_BLOCK  = 4'd3,
      MODE_BSTAR  = 4'd4,
      MODE_NUM    = 4'd5,
      MODE_IDENT  = 4'd6,
      MODE_COPEN  = 4'd7,
      MODE_CCLOSE = 4'd8,
      MODE_STR    = 4'd9,
      MODE_OP     = 4'd10
   } mode_type;

   // token codes
   localparam logic [5:0] TOK_EOF     = 6'd0;
   localparam logic [5:0] TOK_NONE    = 6'd0;  // no operator pair formed
   localparam logic [5:0] TOK_INT     = 6'd1;
   localparam logic [5:0] TOK_IDENT   = 6'd9;
   localparam logic [5:0] TOK_NUMBER  = 6'd10;
   localparam logic [5:0] TOK_CHAR    = 6'd11;
   localparam logic [5:0] TOK_STRING  = 6'd12;
   localparam logic [5:0] TOK_PLUS    = 6'd13;
   localparam logic [5:0] TOK_MINUS   = 6'd14;
   localparam logic [5:0] TOK_STAR    = 6'd15;
   localparam logic [5:0] TOK_DIV     = 6'd16;
   localparam logic [5:0] TOK_MOD     = 6'd17;
   localparam logic [5:0] TOK_ASSIGN  = 6'd18;
   localparam logic [5:0] TOK_EQ      = 6'd19;
   localparam logic [5:0] TOK_NE      = 6'd20;
   localparam logic [5:0] TOK_LT      = 6'd21;
   localparam logic [5:0] TOK_GT      = 6'd22;
   localparam logic [5:0] TOK_LE      = 6'd23;
   localparam logic [5:0] TOK_GE      = 6'd24;
   localparam logic [5:0] TOK_AND     = 6'd25;
   localparam logic [5:0] TOK_OR      = 6'd26;
   localparam logic [5:0] TOK_NOT     = 6'd27;
   localparam logic [5:0] TOK_LPAREN  = 6'd28;
   localparam logic [5:0] TOK_RPAREN  = 6'd29;
   localparam logic [5:0] TOK_LBRACE  = 6'd30;
   localparam logic [5:0] TOK_RBRACE  = 6'd31;
   localparam logic [5:0] TOK_SEMI    = 6'd32;
   localparam logic [5:0] TOK_COMMA   = 6'd33;
   localparam logic [5:0] TOK_UNKNOWN = 6'd34;

   localparam logic [7:0] CH_CR = 8'h0D;

   // keyword table, padded to 7 bytes, first byte in the top bits
   localparam int         KW_COUNT = 8;
   localparam logic [55:0] KW_TEXT [KW_COUNT] = '{
      "int    ", "char   ", "void   ", "if     ",
      "else   ", "while  ", "for    ", "return "
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd3, 3'd4, 3'd4, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6
   };

   // one result beat
   typedef struct packed {
      logic        kind;
      logic [5:0]  ttype;
      logic [7:0]  lbyte;
      logic [7:0]  len;
      logic        sat;
      logic [15:0] line;
      logic [15:0] col;
      logic        last;
   } res_type;

   // results of one source byte
   typedef struct packed {
      logic [1:0]       cnt;
      res_type [1:0]    res;
   } batch_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_alpha(c) || is_digit(c) || (c == "_");
   endfunction

   function automatic logic [5:0] single_type(input logic [7:0] c);
      logic [5:0] t;
      case (c)
         "+":     t = TOK_PLUS;
         "-":     t = TOK_MINUS;
         "*":     t = TOK_STAR;
         "%":     t = TOK_MOD;
         "(":     t = TOK_LPAREN;
         ")":     t = TOK_RPAREN;
         "{":     t = TOK_LBRACE;
         "}":     t = TOK_RBRACE;
         ";":     t = TOK_SEMI;
         ",":     t = TOK_COMMA;
         default: t = TOK_UNKNOWN;
      endcase
      return t;
   endfunction

   // pending operator that no second byte joined
   function automatic logic [5:0] op_alone(input logic [7:0] po);
      logic [5:0] t;
      case (po)
         "=":     t = TOK_ASSIGN;
         "!":     t = TOK_NOT;
         "<":     t = TOK_LT;
         ">":     t = TOK_GT;
         default: t = TOK_UNKNOWN;
      endcase
      return t;
   endfunction

   function automatic logic [5:0] op_pair(input logic [7:0] po, input logic [7:0] c);
      logic [5:0] t;
      case (po)
         "=":     t = (c == "=") ? TOK_EQ : TOK_NONE;
         "!":     t = (c == "=") ? TOK_NE : TOK_NONE;
         "<":     t = (c == "=") ? TOK_LE : TOK_NONE;
         ">":     t = (c == "=") ? TOK_GE : TOK_NONE;
         "&":     t = (c == "&") ? TOK_AND : TOK_NONE;
         "|":     t = (c == "|") ? TOK_OR : TOK_NONE;
         default: t = TOK_NONE;
      endcase
      return t;
   endfunction

   // keyword lookup over the prefix store, identifier when nothing matches
   function automatic logic [5:0] kw_type(input logic [6:0][7:0] pf, input logic [2:0] cnt);
      logic [5:0] t;
      logic       hit;
      t = TOK_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         hit = (cnt == KW_LEN[k]);
         for (int j = 0; j < 7; j++) begin
            if ((3'(j) < KW_LEN[k]) && (pf[j] != KW_TEXT[k][8*(6-j) +: 8])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            t = TOK_INT + 6'(k);
         end
      end
      return t;
   endfunction

endpackage

`default_nettype wire

@@ rtl/clex_core.sv @@
// ----------------------------------------------------------------------------
// clex_core
// scan state registers and the per-byte tokenizer step
// ----------------------------------------------------------------------------
`default_nettype none

module clex_core
   import clex_pkg::*;
#(
   parameter int MAX_LEXEME   = 255,
   parameter int COUNTER_BITS = 16
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      fire,
   input  wire logic [7:0] ch,
   input  wire logic      eoi,
   output batch_type      batch
);

   localparam int LW = $clog2(MAX_LEXEME + 1);
   localparam int CB = COUNTER_BITS;

   mode_type          mode_ff, mode_in;
   logic [CB-1:0]     cur_line_ff, cur_line_in;
   logic [CB-1:0]     cur_col_ff, cur_col_in;
   logic [CB-1:0]     tok_line_ff, tok_line_in;
   logic [CB-1:0]     tok_col_ff, tok_col_in;
   logic [LW-1:0]     lex_cnt_ff, lex_cnt_in;
   logic              lex_over_ff, lex_over_in;
   logic [7:0]        pend_op_ff, pend_op_in;
   logic [6:0][7:0]   prefix_ff, prefix_in;

   function automatic logic [CB-1:0] sat_inc(input logic [CB-1:0] v);
      return (v == {CB{1'b1}}) ? v : v + CB'(1);
   endfunction

   function automatic res_type mk_res(
      input logic          kind,
      input logic [5:0]    tt,
      input logic [7:0]    b,
      input logic [LW-1:0] len,
      input logic          sat,
      input logic [CB-1:0] ln,
      input logic [CB-1:0] cn
   );
      res_type r;
      logic [31:0] len32, ln32, cn32;
      len32   = 32'(len);
      ln32    = 32'(ln);
      cn32    = 32'(cn);
      r.kind  = kind;
      r.ttype = tt;
      r.lbyte = b;
      r.len   = (len32 > 32'd255) ? 8'hFF : len32[7:0];
      r.sat   = sat;
      r.line  = (ln32 > 32'hFFFF) ? 16'hFFFF : ln32[15:0];
      r.col   = (cn32 > 32'hFFFF) ? 16'hFFFF : cn32[15:0];
      r.last  = 1'b0;
      return r;
   endfunction

   always_comb begin
      logic          em1;
      logic [5:0]    em1_t;
      logic          go_start;
      logic          add_req;
      logic [5:0]    add_t;
      logic [5:0]    pair_t;
      logic [5:0]    id_t;
      logic [1:0]    nres;
      res_type [1:0] res;

      mode_in     = mode_ff;
      cur_line_in = cur_line_ff;
      cur_col_in  = cur_col_ff;
      tok_line_in = tok_line_ff;
      tok_col_in  = tok_col_ff;
      lex_cnt_in  = lex_cnt_ff;
      lex_over_in = lex_over_ff;
      pend_op_in  = pend_op_ff;
      prefix_in   = prefix_ff;
      em1         = 1'b0;
      em1_t       = TOK_EOF;
      go_start    = 1'b0;
      add_req     = 1'b0;
      add_t       = TOK_IDENT;
      nres        = 2'd0;
      res         = '0;
      pair_t      = op_pair(pend_op_ff, ch);
      id_t        = (lex_over_ff || (lex_cnt_ff > LW'(6))) ? TOK_IDENT
                                                           : kw_type(prefix_ff, lex_cnt_ff[2:0]);

      if (eoi) begin
         // flush the pending token, then eof at the current position
         unique case (mode_ff)
            MODE_SLASH: begin
               cur_col_in = sat_inc(cur_col_in);
               em1 = 1'b1; em1_t = TOK_DIV;
            end
            MODE_LINE:  cur_col_in = CB'(1);
            MODE_BSTAR: cur_col_in = sat_inc(cur_col_in);
            MODE_NUM:   begin em1 = 1'b1; em1_t = TOK_NUMBER; end
            MODE_IDENT: begin em1 = 1'b1; em1_t = id_t; end
            MODE_COPEN, MODE_CCLOSE: begin em1 = 1'b1; em1_t = TOK_CHAR; end
            MODE_STR:   begin em1 = 1'b1; em1_t = TOK_STRING; end
            MODE_OP:    begin em1 = 1'b1; em1_t = op_alone(pend_op_ff); end
            default: ;
         endcase
         if (em1) begin
            res[nres[0]] = mk_res(1'b1, em1_t, 8'd0, lex_cnt_ff, lex_over_ff,
                                  tok_line_ff, tok_col_ff);
            nres = nres + 2'd1;
         end
         res[nres[0]] = mk_res(1'b1, TOK_EOF, 8'd0, LW'(0), 1'b0, cur_line_in, cur_col_in);
         nres = nres + 2'd1;
         mode_in     = MODE_START;
         cur_line_in = CB'(1);
         cur_col_in  = CB'(1);
         tok_line_in = CB'(1);
         tok_col_in  = CB'(1);
         lex_cnt_in  = '0;
         lex_over_in = 1'b0;
         pend_op_in  = 8'd0;
      end else begin
         unique case (mode_ff)
            MODE_START: go_start = 1'b1;
            MODE_SLASH: begin
               if (ch == "/") begin
                  mode_in = MODE_LINE;
               end else if (ch == "*") begin
                  cur_col_in = sat_inc(sat_inc(cur_col_in));
                  mode_in    = MODE_BLOCK;
               end else begin
                  cur_col_in = sat_inc(cur_col_in);
                  em1 = 1'b1; em1_t = TOK_DIV;
                  go_start = 1'b1;
               end
            end
            MODE_LINE: begin
               if (ch == "\n") begin
                  cur_line_in = sat_inc(cur_line_in);
                  cur_col_in  = CB'(1);
                  mode_in     = MODE_START;
               end
            end
            MODE_BLOCK: begin
               if (ch == "*") begin
                  mode_in = MODE_BSTAR;
               end else if (ch == "\n") begin
                  cur_line_in = sat_inc(cur_line_in);
                  cur_col_in  = CB'(1);
               end else begin
                  cur_col_in = sat_inc(cur_col_in);
               end
            end
            MODE_BSTAR: begin
               cur_col_in = sat_inc(cur_col_in);
               if (ch == "/") begin
                  cur_col_in = sat_inc(cur_col_in);
                  mode_in    = MODE_START;
               end else if (ch == "*") begin
                  mode_in = MODE_BSTAR;
               end else if (ch == "\n") begin
                  cur_line_in = sat_inc(cur_line_in);
                  cur_col_in  = CB'(1);
                  mode_in     = MODE_BLOCK;
               end else begin
                  cur_col_in = sat_inc(cur_col_in);
                  mode_in    = MODE_BLOCK;
               end
            end
            MODE_NUM: begin
               if (is_digit(ch)) begin
                  add_req = 1'b1; add_t = TOK_NUMBER;
                  cur_col_in = sat_inc(cur_col_in);
               end else begin
                  em1 = 1'b1; em1_t = TOK_NUMBER;
                  go_start = 1'b1;
               end
            end
            MODE_IDENT: begin
               if (is_word(ch)) begin
                  add_req = 1'b1; add_t = TOK_IDENT;
                  cur_col_in = sat_inc(cur_col_in);
               end else begin
                  em1 = 1'b1; em1_t = id_t;
                  go_start = 1'b1;
               end
            end
            MODE_COPEN: begin
               cur_col_in = sat_inc(cur_col_in);
               if (ch == "'") begin
                  em1 = 1'b1; em1_t = TOK_CHAR;
                  mode_in = MODE_START;
               end else begin
                  add_req = 1'b1; add_t = TOK_CHAR;
                  mode_in = MODE_CCLOSE;
               end
            end
            MODE_CCLOSE: begin
               em1 = 1'b1; em1_t = TOK_CHAR;
               if (ch == "'") begin
                  cur_col_in = sat_inc(cur_col_in);
                  mode_in    = MODE_START;
               end else begin
                  go_start = 1'b1;
               end
            end
            MODE_STR: begin
               cur_col_in = sat_inc(cur_col_in);
               if (ch == "\"") begin
                  em1 = 1'b1; em1_t = TOK_STRING;
                  mode_in = MODE_START;
               end else begin
                  add_req = 1'b1; add_t = TOK_STRING;
               end
            end
            MODE_OP: begin
               if (pair_t != TOK_NONE) begin
                  cur_col_in = sat_inc(cur_col_in);
                  em1 = 1'b1; em1_t = pair_t;
                  mode_in = MODE_START;
               end else begin
                  em1 = 1'b1; em1_t = op_alone(pend_op_ff);
                  go_start = 1'b1;
               end
            end
            default: go_start = 1'b1;
         endcase

         // token closed by this byte, with the old token fields
         if (em1) begin
            res[nres[0]] = mk_res(1'b1, em1_t, 8'd0, lex_cnt_ff, lex_over_ff,
                                  tok_line_ff, tok_col_ff);
            nres = nres + 2'd1;
         end

         // byte seen from the start mode
         if (go_start) begin
            mode_in = MODE_START;
            if ((ch == " ") || (ch == "\t") || (ch == CH_CR)) begin
               cur_col_in = sat_inc(cur_col_in);
            end else if (ch == "\n") begin
               cur_line_in = sat_inc(cur_line_in);
               cur_col_in  = CB'(1);
            end else begin
               tok_line_in = cur_line_in;
               tok_col_in  = cur_col_in;
               lex_cnt_in  = '0;
               lex_over_in = 1'b0;
               if (ch == "/") begin
                  mode_in = MODE_SLASH;
               end else if (is_digit(ch)) begin
                  add_req = 1'b1; add_t = TOK_NUMBER;
                  cur_col_in = sat_inc(cur_col_in);
                  mode_in    = MODE_NUM;
               end else if (is_alpha(ch) || (ch == "_")) begin
                  add_req = 1'b1; add_t = TOK_IDENT;
                  cur_col_in = sat_inc(cur_col_in);
                  mode_in    = MODE_IDENT;
               end else begin
                  cur_col_in = sat_inc(cur_col_in);
                  if (ch == "'") begin
                     mode_in = MODE_COPEN;
                  end else if (ch == "\"") begin
                     mode_in = MODE_STR;
                  end else if ((ch == "=") || (ch == "!") || (ch == "<") || (ch == ">")
                               || (ch == "&") || (ch == "|")) begin
                     pend_op_in = ch;
                     mode_in    = MODE_OP;
                  end else begin
                     res[nres[0]] = mk_res(1'b1, single_type(ch), 8'd0, LW'(0), 1'b0,
                                           tok_line_in, tok_col_in);
                     nres = nres + 2'd1;
                  end
               end
            end
         end

         // lexeme byte, always the final beat of the step
         if (add_req) begin
            if (lex_cnt_in < LW'(MAX_LEXEME)) begin
               if (lex_cnt_in < LW'(7)) begin
                  prefix_in[lex_cnt_in[2:0]] = ch;
               end
               lex_cnt_in = lex_cnt_in + LW'(1);
               res[nres[0]] = mk_res(1'b0, add_t, ch, lex_cnt_in, 1'b0,
                                     tok_line_in, tok_col_in);
               nres = nres + 2'd1;
            end else begin
               lex_over_in = 1'b1;
            end
         end
      end

      res[0].last = (nres == 2'd1);
      res[1].last = 1'b1;
      batch.cnt   = nres;
      batch.res   = res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_START;
         cur_line_ff <= CB'(1);
         cur_col_ff  <= CB'(1);
         tok_line_ff <= CB'(1);
         tok_col_ff  <= CB'(1);
         lex_cnt_ff  <= '0;
         lex_over_ff <= 1'b0;
         pend_op_ff  <= 8'd0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         cur_line_ff <= cur_line_in;
         cur_col_ff  <= cur_col_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff  <= tok_col_in;
         lex_cnt_ff  <= lex_cnt_in;
         lex_over_ff <= lex_over_in;
         pend_op_ff  <= pend_op_in;
      end
   end

   // prefix store, only read at entries written for the current lexeme
   always_ff @(posedge clock) begin
      if (fire) begin
         prefix_ff <= prefix_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/clex_rsp.sv @@
// ----------------------------------------------------------------------------
// clex_rsp
// result register, holds the beats of one source byte and drains them
// ----------------------------------------------------------------------------
`default_nettype none

module clex_rsp
   import clex_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      load,
   input  batch_type      batch,
   input  wire logic      rsp_tready,
   output logic           rsp_tvalid,
   output res_type        rsp_res,
   output logic           free
);

   res_type [1:0] slot_ff, slot_in;
   logic [1:0]    cnt_ff, cnt_in;
   logic          idx_ff, idx_in;
   logic          final_beat;

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_res    = slot_ff[idx_ff];
   assign final_beat = (cnt_ff == 2'd1) || idx_ff;
   assign free       = !rsp_tvalid || (rsp_tready && final_beat);

   always_comb begin
      slot_in = slot_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      if (load) begin
         slot_in = batch.res;
         cnt_in  = batch.cnt;
         idx_in  = 1'b0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (final_beat) begin
            cnt_in = 2'd0;
            idx_in = 1'b0;
         end else begin
            idx_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         idx_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
   end

endmodule

`default_nettype wire

@@ rtl/c_subset_lexer.sv @@
// ----------------------------------------------------------------------------
// c_subset_lexer
// streaming tokenizer for a small c subset, one source byte per beat
// ----------------------------------------------------------------------------
//
// channel   dir  beat contents
// req_      in   tdata ch, tuser end_of_input
// rsp_      out  tdata token fields, tuser item_kind, tlast last of the byte
//
// one source byte is taken per cycle while the result register has room; a
// byte that gives two result beats holds the input register while the
// result register drains; path: input register, scan step, result register;
// the first beat shows once the step has loaded the result register
// reset is synchronous: scan mode to start, line and column to 1, the
// keyword prefix store is not cleared
// rsp_tready low holds the result register; the input register still takes
// one more byte
// ----------------------------------------------------------------------------
`default_nettype none

module c_subset_lexer
   import clex_pkg::*;
#(
   parameter int MAX_LEXEME   = 255,
   parameter int COUNTER_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // source byte channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] ch
   input  wire logic [0:0]  req_tuser,   // [0] end_of_input
   // result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [5:0] token_type, [13:6] lexeme_byte,
                                         // [21:14] lexeme_length, [22] length_saturated,
                                         // [38:23] start_line, [54:39] start_column,
                                         // [55] zero
   output logic [0:0]       rsp_tuser,   // [0] item_kind
   output logic             rsp_tlast    // last beat caused by one source byte
);

`include "assert_macros.svh"

   // input register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_ch_ff, in_ch_in;
   logic       in_eoi_ff, in_eoi_in;

   logic       fire;       // step taken this cycle
   logic       rsp_free;   // result register can take a new batch
   batch_type  batch;
   res_type    rsp_res;

   // step only when the result register has room for both beats
   assign fire       = in_valid_ff && rsp_free;
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_ch_in    = in_ch_ff;
      in_eoi_in   = in_eoi_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
         in_ch_in    = req_tdata[7:0];
         in_eoi_in   = req_tuser[0];
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ch_ff  <= in_ch_in;
      in_eoi_ff <= in_eoi_in;
   end

   // scan state and per-byte step
   clex_core #(
      .MAX_LEXEME   (MAX_LEXEME),
      .COUNTER_BITS (COUNTER_BITS)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .ch    (in_ch_ff),
      .eoi   (in_eoi_ff),
      .batch (batch)
   );

   // result register and beat sequencing
   clex_rsp u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .batch      (batch),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_res    (rsp_res),
      .free       (rsp_free)
   );

   assign rsp_tdata = {1'b0, rsp_res.col, rsp_res.line, rsp_res.sat, rsp_res.len,
                       rsp_res.lbyte, rsp_res.ttype};
   assign rsp_tuser = rsp_res.kind;
   assign rsp_tlast = rsp_res.last;

   // eof closes the results of its byte
   `CHECK_IMPL(a_eof_last, clock, reset, rsp_tvalid && rsp_res.kind && rsp_res.ttype == TOK_EOF, rsp_tlast)
   // lexeme byte beats never carry the overflow flag
   `CHECK_IMPL(a_byte_no_sat, clock, reset, rsp_tvalid && !rsp_res.kind, !rsp_res.sat)
   // a step that makes beats shows them in the next cycle
   `CHECK_NEXT(a_batch_shown, clock, reset, fire && batch.cnt != 2'd0, rsp_tvalid)
   // an unstepped byte stays in the input register
   `CHECK_NEXT(a_hold_input, clock, reset, in_valid_ff && !fire, in_valid_ff && $stable(in_ch_ff))

endmodule

`default_nettype wire
